>>> sv/vtbh_pkg.sv
// vtbh_pkg: shared types and constants for the vertex transform / bounding box block
// no dependencies
package vtbh_pkg;

    localparam int CoordW   = 16;
    localparam int FracBits = 12;
    localparam int CoefW    = 16;
    localparam int RowW     = 64;
    // row dot product: three 16x16 products plus w term, exact
    localparam int DotW     = 2 * CoordW + 2;
    // dividend widened by the fraction bits
    localparam int NumW     = DotW + FracBits;
    localparam int QW       = NumW;
    localparam int QCntW    = $clog2(NumW + 1);
    localparam int CfgIdxW  = 3;
    localparam int CfgDatW  = 64;
    localparam int QDepth   = 4;
    localparam int QPtrW    = 2;

    localparam logic [CfgIdxW-1:0] RegRow0   = 3'd0;
    localparam logic [CfgIdxW-1:0] RegRow1   = 3'd1;
    localparam logic [CfgIdxW-1:0] RegRow2   = 3'd2;
    localparam logic [CfgIdxW-1:0] RegRow3   = 3'd3;
    localparam logic [CfgIdxW-1:0] RegClickX = 3'd4;
    localparam logic [CfgIdxW-1:0] RegClickY = 3'd5;

    // one transformed vertex handed from front to back
    typedef struct packed {
        logic signed [DotW-1:0] hx;
        logic signed [DotW-1:0] hy;
        logic signed [DotW-1:0] hw;
        logic                   zero_w;
        logic                   last;
    } vtbh_item_t;

    function automatic logic signed [CoefW-1:0] coef_of(input logic [RowW-1:0] row,
                                                        input int k);
        coef_of = row[16*k +: 16];
    endfunction

endpackage

>>> sv/vtbh_front.sv
// vtbh_front: accepts vertices, computes x', y', w over two stages
// depends on vtbh_pkg
module vtbh_front (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic [vtbh_pkg::RowW-1:0]    row_x,
    input  logic [vtbh_pkg::RowW-1:0]    row_y,
    input  logic [vtbh_pkg::RowW-1:0]    row_w,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic signed [vtbh_pkg::CoordW-1:0] s_vert_x,
    input  logic signed [vtbh_pkg::CoordW-1:0] s_vert_y,
    input  logic signed [vtbh_pkg::CoordW-1:0] s_vert_z,
    input  logic                         s_last_vertex,
    output logic                         o_valid,
    input  logic                         o_ready,
    output vtbh_pkg::vtbh_item_t         o_item
);
    import vtbh_pkg::*;

    localparam int PW = 2 * CoordW;

    // stage 1: twelve products registered
    logic                 p_valid_reg;
    logic signed [PW-1:0] prod_reg [3][4];
    logic                 p_last_reg;
    logic                 advance;
    logic                 p_take;
    logic signed [DotW-1:0] sum [3];
    logic [RowW-1:0]      rows [3];

    assign rows[0] = row_x;
    assign rows[1] = row_y;
    assign rows[2] = row_w;

    // stage 2 output register
    assign advance = !o_valid || o_ready;
    assign p_take  = p_valid_reg && advance;
    assign s_ready = !p_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p_valid_reg <= 1'b0;
        end else if (s_ready) begin
            p_valid_reg <= s_valid;
        end
        if (s_valid && s_ready) begin
            for (int r = 0; r < 3; r++) begin
                prod_reg[r][0] <= PW'(coef_of(rows[r], 0) * s_vert_x);
                prod_reg[r][1] <= PW'(coef_of(rows[r], 1) * s_vert_y);
                prod_reg[r][2] <= PW'(coef_of(rows[r], 2) * s_vert_z);
                prod_reg[r][3] <= PW'(coef_of(rows[r], 3) * $signed(PW'(1 << FracBits)));
            end
            p_last_reg <= s_last_vertex;
        end
    end

    always_comb begin
        for (int r = 0; r < 3; r++) begin
            sum[r] = DotW'(prod_reg[r][0]) + DotW'(prod_reg[r][1])
                   + DotW'(prod_reg[r][2]) + DotW'(prod_reg[r][3]);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            o_valid <= 1'b0;
        end else if (advance) begin
            o_valid <= p_valid_reg;
        end
        if (p_take) begin
            o_item.hx     <= sum[0];
            o_item.hy     <= sum[1];
            o_item.hw     <= sum[2];
            o_item.zero_w <= (sum[2] == '0);
            o_item.last   <= p_last_reg;
        end
    end

endmodule

>>> sv/vtbh_queue.sv
// vtbh_queue: short fifo between front and back
// depends on vtbh_pkg
module vtbh_queue (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 i_valid,
    output logic                 i_ready,
    input  vtbh_pkg::vtbh_item_t i_item,
    output logic                 o_valid,
    input  logic                 o_ready,
    output vtbh_pkg::vtbh_item_t o_item
);
    import vtbh_pkg::*;

    vtbh_item_t       mem_reg [QDepth];
    logic [QPtrW-1:0] wr_reg, rd_reg;
    logic [QPtrW:0]   cnt_reg;
    logic             push, pop;

    assign i_ready = (cnt_reg != (QPtrW+1)'(QDepth));
    assign o_valid = (cnt_reg != '0);
    assign o_item  = mem_reg[rd_reg];
    assign push    = i_valid && i_ready;
    assign pop     = o_valid && o_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end else begin
            if (push) wr_reg <= wr_reg + 1'b1;
            if (pop)  rd_reg <= rd_reg + 1'b1;
            cnt_reg <= cnt_reg + (QPtrW+1)'(push) - (QPtrW+1)'(pop);
        end
        if (push) mem_reg[wr_reg] <= i_item;
    end

endmodule

>>> sv/vtbh_back.sv
// vtbh_back: serial divides x'/w and y'/w, keeps the running box, emits result
// depends on vtbh_pkg
module vtbh_back (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic signed [vtbh_pkg::CoordW-1:0] click_x,
    input  logic signed [vtbh_pkg::CoordW-1:0] click_y,
    input  logic                              i_valid,
    output logic                              i_ready,
    input  vtbh_pkg::vtbh_item_t              i_item,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic                              m_hit,
    output logic signed [vtbh_pkg::CoordW-1:0] m_box_min_x,
    output logic signed [vtbh_pkg::CoordW-1:0] m_box_max_x,
    output logic signed [vtbh_pkg::CoordW-1:0] m_box_min_y,
    output logic signed [vtbh_pkg::CoordW-1:0] m_box_max_y,
    output logic                              m_zero_w_seen,
    output logic                              m_box_valid
);
    import vtbh_pkg::*;

    typedef enum logic [1:0] {S_IDLE, S_DIV, S_UPD, S_EMIT} state_t;

    localparam logic [NumW-1:0] Lim = NumW'(1) << (CoordW - 1);

    state_t            state_reg;
    logic              sel_y_reg;       // 0: dividing x, 1: dividing y
    logic [QCntW-1:0]  cnt_reg;
    logic [NumW-1:0]   num_reg;         // shifts out dividend bits
    logic [DotW:0]     rem_reg;
    logic [QW-1:0]     q_reg;
    logic [DotW-1:0]   den_reg;
    logic              neg_reg;
    logic [DotW-1:0]   hy_mag_reg;
    logic              hy_neg_reg;
    logic              last_reg, zw_reg;
    logic signed [CoordW-1:0] px_reg, py_reg;
    logic signed [CoordW-1:0] mnx_reg, mxx_reg, mny_reg, mxy_reg;
    logic              have_reg, zflag_reg;

    logic [DotW:0]     rem_sh;
    logic              ge;
    logic [DotW-1:0]   hx_mag, hy_mag, hw_mag;
    logic signed [CoordW-1:0] sat_val;
    logic [QW-1:0]     qf;
    logic              emit_go;

    assign hx_mag = i_item.hx[DotW-1] ? DotW'(-i_item.hx) : DotW'(i_item.hx);
    assign hy_mag = i_item.hy[DotW-1] ? DotW'(-i_item.hy) : DotW'(i_item.hy);
    assign hw_mag = i_item.hw[DotW-1] ? DotW'(-i_item.hw) : DotW'(i_item.hw);

    // restoring divide, one quotient bit per cycle
    assign rem_sh = {rem_reg[DotW-1:0], num_reg[NumW-1]};
    assign ge     = rem_sh >= {1'b0, den_reg};
    assign qf     = {q_reg[QW-2:0], ge};

    // saturate final quotient magnitude
    always_comb begin
        if (neg_reg) begin
            sat_val = (qf >= Lim) ? CoordW'(-Lim) : CoordW'(-qf);
        end else begin
            sat_val = (qf >= Lim) ? CoordW'(Lim - 1) : CoordW'(qf);
        end
    end

    assign i_ready = (state_reg == S_IDLE);

    // result register free to take the box
    assign emit_go = (state_reg == S_EMIT) && (!m_valid || m_ready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            m_valid   <= 1'b0;
            have_reg  <= 1'b0;
            zflag_reg <= 1'b0;
            mnx_reg   <= '0;
            mxx_reg   <= '0;
            mny_reg   <= '0;
            mxy_reg   <= '0;
        end else begin
            if (emit_go) begin
                m_valid <= 1'b1;
            end else if (m_ready) begin
                m_valid <= 1'b0;
            end
            case (state_reg)
                S_IDLE: begin
                    if (i_valid) begin
                        last_reg <= i_item.last;
                        zw_reg   <= i_item.zero_w;
                        if (i_item.zero_w) begin
                            state_reg <= S_UPD;
                        end else begin
                            num_reg    <= NumW'(hx_mag) << FracBits;
                            rem_reg    <= '0;
                            q_reg      <= '0;
                            den_reg    <= hw_mag;
                            neg_reg    <= i_item.hx[DotW-1] ^ i_item.hw[DotW-1];
                            hy_mag_reg <= hy_mag;
                            hy_neg_reg <= i_item.hy[DotW-1] ^ i_item.hw[DotW-1];
                            sel_y_reg  <= 1'b0;
                            cnt_reg    <= '0;
                            state_reg  <= S_DIV;
                        end
                    end
                end
                S_DIV: begin
                    if (cnt_reg == QCntW'(NumW - 1)) begin
                        if (!sel_y_reg) begin
                            px_reg    <= sat_val;
                            num_reg   <= NumW'(hy_mag_reg) << FracBits;
                            rem_reg   <= '0;
                            q_reg     <= '0;
                            neg_reg   <= hy_neg_reg;
                            sel_y_reg <= 1'b1;
                            cnt_reg   <= '0;
                        end else begin
                            py_reg    <= sat_val;
                            state_reg <= S_UPD;
                        end
                    end else begin
                        rem_reg <= ge ? rem_sh - {1'b0, den_reg} : rem_sh;
                        num_reg <= num_reg << 1;
                        q_reg   <= qf;
                        cnt_reg <= cnt_reg + 1'b1;
                    end
                end
                S_UPD: begin
                    if (zw_reg) begin
                        zflag_reg <= 1'b1;
                    end else if (!have_reg) begin
                        mnx_reg <= px_reg;
                        mxx_reg <= px_reg;
                        mny_reg <= py_reg;
                        mxy_reg <= py_reg;
                        have_reg <= 1'b1;
                    end else begin
                        if (px_reg < mnx_reg) mnx_reg <= px_reg;
                        if (px_reg > mxx_reg) mxx_reg <= px_reg;
                        if (py_reg < mny_reg) mny_reg <= py_reg;
                        if (py_reg > mxy_reg) mxy_reg <= py_reg;
                    end
                    state_reg <= last_reg ? S_EMIT : S_IDLE;
                end
                S_EMIT: begin
                    if (emit_go) begin
                        m_hit         <= have_reg && click_x >= mnx_reg && click_x <= mxx_reg
                                         && click_y >= mny_reg && click_y <= mxy_reg;
                        m_box_min_x   <= mnx_reg;
                        m_box_max_x   <= mxx_reg;
                        m_box_min_y   <= mny_reg;
                        m_box_max_y   <= mxy_reg;
                        m_zero_w_seen <= zflag_reg;
                        m_box_valid   <= have_reg;
                        have_reg      <= 1'b0;
                        zflag_reg     <= 1'b0;
                        mnx_reg       <= '0;
                        mxx_reg       <= '0;
                        mny_reg       <= '0;
                        mxy_reg       <= '0;
                        state_reg     <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

endmodule

>>> sv/vertex_transform_bbox_hit_top.sv
// vertex_transform_bbox_hit_top: transforms vertices, divides by w, tracks box, tests click
// depends on vtbh_pkg, vtbh_front, vtbh_queue, vtbh_back
//
//  channel  dir  handshake          payload
//  s_       in   s_valid/s_ready    s_vert_x, s_vert_y, s_vert_z, s_last_vertex
//  m_       out  m_valid/m_ready    m_hit, m_box_*, m_zero_w_seen, m_box_valid
//  cfg_     in   cfg_valid/ready    cfg_index, cfg_data
//
// front: a multiply stage then an add stage per vertex, one vertex per cycle while the queue has room
// back: two serial restoring divides per vertex with nonzero w and none with zero w,
//   taking the next vertex only when idle; a last vertex then passes through an emit state
// a four-entry queue lets the front keep taking vertices while the back divides
// aresetn is synchronous, active low; registers return to identity matrix, click 0
module vertex_transform_bbox_hit_top (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic signed [15:0] s_vert_x,
    input  logic signed [15:0] s_vert_y,
    input  logic signed [15:0] s_vert_z,
    input  logic        s_last_vertex,
    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_hit,
    output logic signed [15:0] m_box_min_x,
    output logic signed [15:0] m_box_max_x,
    output logic signed [15:0] m_box_min_y,
    output logic signed [15:0] m_box_max_y,
    output logic        m_zero_w_seen,
    output logic        m_box_valid,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [vtbh_pkg::CfgIdxW-1:0] cfg_index,
    input  logic [vtbh_pkg::CfgDatW-1:0] cfg_data
);
    import vtbh_pkg::*;

    logic [RowW-1:0] row0_reg, row1_reg, row3_reg;
    logic signed [CoordW-1:0] click_x_reg, click_y_reg;

    logic       f_valid, f_ready, q_valid, q_ready;
    vtbh_item_t f_item, q_item;

    // config always accepted; row 2 only feeds z', which nothing uses, so it is not kept
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row0_reg    <= RowW'(1) << FracBits;
            row1_reg    <= RowW'(1) << (FracBits + 16);
            row3_reg    <= RowW'(1) << (FracBits + 48);
            click_x_reg <= '0;
            click_y_reg <= '0;
        end else if (cfg_valid) begin
            case (cfg_index)
                RegRow0:   row0_reg    <= cfg_data;
                RegRow1:   row1_reg    <= cfg_data;
                RegRow2:   ;
                RegRow3:   row3_reg    <= cfg_data;
                RegClickX: click_x_reg <= cfg_data[CoordW-1:0];
                RegClickY: click_y_reg <= cfg_data[CoordW-1:0];
                default: ;
            endcase
        end
    end

    vtbh_front u_front (
        .aclk, .aresetn,
        .row_x(row0_reg), .row_y(row1_reg), .row_w(row3_reg),
        .s_valid, .s_ready, .s_vert_x, .s_vert_y, .s_vert_z, .s_last_vertex,
        .o_valid(f_valid), .o_ready(f_ready), .o_item(f_item)
    );

    vtbh_queue u_queue (
        .aclk, .aresetn,
        .i_valid(f_valid), .i_ready(f_ready), .i_item(f_item),
        .o_valid(q_valid), .o_ready(q_ready), .o_item(q_item)
    );

    vtbh_back u_back (
        .aclk, .aresetn,
        .click_x(click_x_reg), .click_y(click_y_reg),
        .i_valid(q_valid), .i_ready(q_ready), .i_item(q_item),
        .m_valid, .m_ready, .m_hit,
        .m_box_min_x, .m_box_max_x, .m_box_min_y, .m_box_max_y,
        .m_zero_w_seen, .m_box_valid
    );

    // a hit needs a nonempty box
    a_hit_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_hit |-> m_box_valid)
        else $error("hit without box");

    // empty box reports zeros
    a_empty_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_box_valid |-> m_box_min_x == '0 && m_box_max_y == '0 && !m_hit)
        else $error("empty box not zero");

    // box ordered
    a_box_order: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_box_min_x <= m_box_max_x && m_box_min_y <= m_box_max_y)
        else $error("box misordered");

endmodule
